// File: rtl/rk4sou_pkg.sv
// Shared types, constants and fixed-point helpers of the RK4 second-order stage update.
// Used by every interface and module of the block; depends on nothing.
`default_nettype none

package rk4sou_pkg;

	localparam int DW       = 32;
	localparam int PW       = 2 * DW;
	localparam int FRAC     = 16;
	localparam int OPW      = 3;
	localparam int IDXW     = 10;
	localparam int NUM_VARS = 1024;
	localparam int CFG_IW   = 2;

	localparam int IQ_DEPTH = 4;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
	localparam int OQ_DEPTH = 16;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	localparam logic [OPW-1:0] OP_LOAD = 3'd0;
	localparam logic [OPW-1:0] OP_ST1  = 3'd1;
	localparam logic [OPW-1:0] OP_ST2  = 3'd2;
	localparam logic [OPW-1:0] OP_ST3  = 3'd3;
	localparam logic [OPW-1:0] OP_ST4  = 3'd4;

	localparam logic [2:0] K_LOAD = 3'd0;
	localparam logic [2:0] K_ST1  = 3'd1;
	localparam logic [2:0] K_ST2  = 3'd2;
	localparam logic [2:0] K_ST3  = 3'd3;
	localparam logic [2:0] K_ST4  = 3'd4;
	localparam logic [2:0] K_NOP  = 3'd5;
	localparam logic [2:0] K_OOR  = 3'd6;

	localparam logic [CFG_IW-1:0] CFG_STEP     = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_POS_HALF = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_POS_CORR = 2'd2;

	localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] SIXTH_Q = DW'(10923);
	localparam logic signed [PW-1:0] ROUND_Q = PW'(1) <<< (FRAC - 1);

	typedef struct packed {
		logic                 clamp;
		logic signed [DW-1:0] val;
	} sval_t;

	typedef struct packed {
		logic signed [DW-1:0] step;
		logic signed [DW-1:0] pos_half;
		logic signed [DW-1:0] pos_corr;
	} cfg_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic [IDXW-1:0]      var_index;
		logic signed [DW-1:0] accel;
		logic signed [DW-1:0] load_pos;
		logic signed [DW-1:0] load_vel;
	} item_t;

	typedef struct packed {
		logic [IDXW-1:0]      out_index;
		logic signed [DW-1:0] out_pos;
		logic signed [DW-1:0] out_vel;
		logic                 saturated;
	} res_t;

	function automatic sval_t sat_add(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
		logic [DW:0] s;
		sval_t       r;
		s = {a[DW-1], a} + {b[DW-1], b};
		r.clamp = s[DW] ^ s[DW-1];
		r.val   = r.clamp ? (s[DW] ? SAT_MIN : SAT_MAX) : s[DW-1:0];
		return r;
	endfunction

	function automatic logic signed [PW-1:0] mul_full(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		logic signed [PW-1:0] p;
		p = a * b;
		return p;
	endfunction

	function automatic sval_t rnd_sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] q;
		logic signed [PW-1:0] sh;
		logic [PW-DW:0]       hi;
		sval_t                r;
		q  = p + ROUND_Q;
		sh = q >>> FRAC;
		hi = sh[PW-1:DW-1];
		r.clamp = !((&hi) || !(|hi));
		r.val   = r.clamp ? (sh[PW-1] ? SAT_MIN : SAT_MAX) : sh[DW-1:0];
		return r;
	endfunction

	// times one half, rounded half up
	function automatic logic signed [DW-1:0] half(input logic signed [DW-1:0] x);
		logic [DW:0] t;
		t = {x[DW-1], x} + (DW+1)'(1);
		return t[DW:1];
	endfunction

endpackage

`default_nettype wire

// File: rtl/rk4sou_req_if.sv
// Input item channel of the RK4 stage update: valid/ready plus item payload.
// Depends on rk4sou_pkg for field widths.
`default_nettype none

interface rk4sou_req_if;
	logic                             valid;
	logic                             ready;
	logic [rk4sou_pkg::OPW-1:0]       opcode;
	logic [rk4sou_pkg::IDXW-1:0]      var_index;
	logic signed [rk4sou_pkg::DW-1:0] accel;
	logic signed [rk4sou_pkg::DW-1:0] load_pos;
	logic signed [rk4sou_pkg::DW-1:0] load_vel;

	modport source (output valid, output opcode, output var_index, output accel,
		output load_pos, output load_vel, input ready);
	modport sink (input valid, input opcode, input var_index, input accel,
		input load_pos, input load_vel, output ready);
endinterface

`default_nettype wire

// File: rtl/rk4sou_rsp_if.sv
// Result item channel of the RK4 stage update: valid/ready plus result payload.
// Depends on rk4sou_pkg for field widths.
`default_nettype none

interface rk4sou_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [rk4sou_pkg::IDXW-1:0]      out_index;
	logic signed [rk4sou_pkg::DW-1:0] out_pos;
	logic signed [rk4sou_pkg::DW-1:0] out_vel;
	logic                             saturated;

	modport source (output valid, output out_index, output out_pos, output out_vel,
		output saturated, input ready);
	modport sink (input valid, input out_index, input out_pos, input out_vel,
		input saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/rk4sou_cfg_if.sv
// Configuration write channel of the RK4 stage update: valid/ready, index, data.
// Depends on rk4sou_pkg for widths.
`default_nettype none

interface rk4sou_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rk4sou_pkg::CFG_IW-1:0] index;
	logic [rk4sou_pkg::DW-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/rk4sou_front.sv
// Front end: configuration registers, opcode/index classification and input item queue.
// Depends on rk4sou_pkg, rk4sou_req_if and rk4sou_cfg_if.
`default_nettype none

module rk4sou_front (
	input  logic                  clk,
	input  logic                  arst_n,
	rk4sou_req_if.sink            req,
	rk4sou_cfg_if.sink            cfg,
	output rk4sou_pkg::cfg_t      cfg_regs,
	output rk4sou_pkg::item_t     head,
	output logic                  head_valid,
	input  logic                  head_pop
);

	rk4sou_pkg::cfg_t                cfg_q;
	rk4sou_pkg::item_t               iq_q [rk4sou_pkg::IQ_DEPTH];
	logic [rk4sou_pkg::IQ_AW-1:0]    wr_ptr_q;
	logic [rk4sou_pkg::IQ_AW-1:0]    rd_ptr_q;
	logic [rk4sou_pkg::IQ_CW-1:0]    cnt_q;
	rk4sou_pkg::item_t               entry;
	logic                            push;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rk4sou_pkg::CFG_STEP:     cfg_q.step     <= cfg.data;
				rk4sou_pkg::CFG_POS_HALF: cfg_q.pos_half <= cfg.data;
				rk4sou_pkg::CFG_POS_CORR: cfg_q.pos_corr <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		entry.var_index = req.var_index;
		entry.accel     = req.accel;
		entry.load_pos  = req.load_pos;
		entry.load_vel  = req.load_vel;
		unique case (req.opcode)
			rk4sou_pkg::OP_LOAD: entry.kind = rk4sou_pkg::K_LOAD;
			rk4sou_pkg::OP_ST1:  entry.kind = rk4sou_pkg::K_ST1;
			rk4sou_pkg::OP_ST2:  entry.kind = rk4sou_pkg::K_ST2;
			rk4sou_pkg::OP_ST3:  entry.kind = rk4sou_pkg::K_ST3;
			rk4sou_pkg::OP_ST4:  entry.kind = rk4sou_pkg::K_ST4;
			default:             entry.kind = rk4sou_pkg::K_NOP;
		endcase
		if (!(32'(req.var_index) < 32'(rk4sou_pkg::NUM_VARS))) begin
			entry.kind = rk4sou_pkg::K_OOR;
		end
	end

	assign req.ready  = (cnt_q != rk4sou_pkg::IQ_CW'(rk4sou_pkg::IQ_DEPTH));
	assign push       = req.valid && req.ready;
	assign head_valid = (cnt_q != '0);
	assign head       = iq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			iq_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rk4sou_pkg::IQ_AW'(1);
			end
			if (head_pop) begin
				rd_ptr_q <= rd_ptr_q + rk4sou_pkg::IQ_AW'(1);
			end
			case ({push, head_pop})
				2'b10:   cnt_q <= cnt_q + rk4sou_pkg::IQ_CW'(1);
				2'b01:   cnt_q <= cnt_q - rk4sou_pkg::IQ_CW'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/rk4sou_back.sv
// Back end: per-variable state memories and the eight-stage fixed-point stage pipeline.
// Depends on rk4sou_pkg; fed by rk4sou_front, drains into rk4sou_outq.
`default_nettype none

module rk4sou_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rk4sou_pkg::cfg_t      cfg_regs,
	input  rk4sou_pkg::item_t     head,
	input  logic                  head_valid,
	output logic                  head_pop,
	output rk4sou_pkg::res_t      res,
	output logic                  res_push,
	input  logic                  res_pop
);

	typedef struct packed {
		logic [2:0]                       kind;
		logic [rk4sou_pkg::IDXW-1:0]      idx;
		logic                             clamp;
		logic signed [rk4sou_pkg::DW-1:0] acc;
		logic signed [rk4sou_pkg::DW-1:0] pos;
		logic signed [rk4sou_pkg::DW-1:0] vel;
		logic signed [rk4sou_pkg::DW-1:0] sp;
		logic signed [rk4sou_pkg::DW-1:0] sv;
		logic signed [rk4sou_pkg::DW-1:0] i1;
		logic signed [rk4sou_pkg::DW-1:0] i2;
		logic signed [rk4sou_pkg::DW-1:0] i3;
		logic signed [rk4sou_pkg::DW-1:0] wa;
		logic signed [rk4sou_pkg::DW-1:0] wb;
		logic signed [rk4sou_pkg::DW-1:0] wc;
		logic signed [rk4sou_pkg::DW-1:0] wd;
		logic signed [rk4sou_pkg::PW-1:0] pa;
		logic signed [rk4sou_pkg::PW-1:0] pb;
	} pipe_t;

	logic [rk4sou_pkg::DW-1:0] pos_mem    [rk4sou_pkg::NUM_VARS];
	logic [rk4sou_pkg::DW-1:0] vel_mem    [rk4sou_pkg::NUM_VARS];
	logic [rk4sou_pkg::DW-1:0] spos_mem   [rk4sou_pkg::NUM_VARS];
	logic [rk4sou_pkg::DW-1:0] svel_mem   [rk4sou_pkg::NUM_VARS];
	logic [rk4sou_pkg::DW-1:0] inc1_mem   [rk4sou_pkg::NUM_VARS];
	logic [rk4sou_pkg::DW-1:0] inc2_mem   [rk4sou_pkg::NUM_VARS];
	logic [rk4sou_pkg::DW-1:0] inc3_mem   [rk4sou_pkg::NUM_VARS];

	logic signed [rk4sou_pkg::DW-1:0] pos_rd_q, vel_rd_q, spos_rd_q, svel_rd_q;
	logic signed [rk4sou_pkg::DW-1:0] inc1_rd_q, inc2_rd_q, inc3_rd_q;

	pipe_t pipe_s1, pipe_s2, pipe_s3, pipe_s4, pipe_s5, pipe_s6, pipe_s7, pipe_s8;
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	pipe_t n1, n2, n3, n4, n5, n6, n7, n8, fin;

	logic [rk4sou_pkg::OQ_CW-1:0] cred_q;
	logic                         hazard;
	logic                         issue;
	logic                         wr_pv, wr_start, wr_i2, wr_i3;

	// block a variable that is still in flight until its write-back is done
	always_comb begin
		hazard = (vld_s1 && pipe_s1.idx == head.var_index)
			|| (vld_s2 && pipe_s2.idx == head.var_index)
			|| (vld_s3 && pipe_s3.idx == head.var_index)
			|| (vld_s4 && pipe_s4.idx == head.var_index)
			|| (vld_s5 && pipe_s5.idx == head.var_index)
			|| (vld_s6 && pipe_s6.idx == head.var_index)
			|| (vld_s7 && pipe_s7.idx == head.var_index)
			|| (vld_s8 && pipe_s8.idx == head.var_index);
	end

	assign issue    = head_valid && !hazard
		&& (cred_q < rk4sou_pkg::OQ_CW'(rk4sou_pkg::OQ_DEPTH));
	assign head_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
		end else begin
			case ({issue, res_pop})
				2'b10:   cred_q <= cred_q + rk4sou_pkg::OQ_CW'(1);
				2'b01:   cred_q <= cred_q - rk4sou_pkg::OQ_CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_rd_q  <= pos_mem[head.var_index];
			vel_rd_q  <= vel_mem[head.var_index];
			spos_rd_q <= spos_mem[head.var_index];
			svel_rd_q <= svel_mem[head.var_index];
			inc1_rd_q <= inc1_mem[head.var_index];
			inc2_rd_q <= inc2_mem[head.var_index];
			inc3_rd_q <= inc3_mem[head.var_index];
		end
	end

	always_comb begin
		n1      = '0;
		n1.kind = head.kind;
		n1.idx  = head.var_index;
		n1.acc  = head.accel;
		n1.wa   = head.load_pos;
		n1.wb   = head.load_vel;
	end

	always_comb begin : st1
		rk4sou_pkg::sval_t                ad;
		logic signed [rk4sou_pkg::DW-1:0] mx, mf, ax, ay;
		pipe_t                            c;
		c     = pipe_s1;
		c.pos = pos_rd_q;
		c.vel = vel_rd_q;
		c.sp  = spos_rd_q;
		c.sv  = svel_rd_q;
		c.i1  = inc1_rd_q;
		c.i2  = inc2_rd_q;
		c.i3  = inc3_rd_q;
		case (pipe_s1.kind)
			rk4sou_pkg::K_LOAD: begin
				c.pos = pipe_s1.wa;
				c.vel = pipe_s1.wb;
			end
			rk4sou_pkg::K_ST1: begin
				c.sp = pos_rd_q;
				c.sv = vel_rd_q;
			end
			rk4sou_pkg::K_OOR: begin
				c.pos = '0;
				c.vel = '0;
			end
			default: ;
		endcase
		mx = (pipe_s1.kind == rk4sou_pkg::K_ST1) ? c.vel : c.i1;
		mf = (pipe_s1.kind == rk4sou_pkg::K_ST1) ? cfg_regs.pos_half : cfg_regs.pos_corr;
		ax = (pipe_s1.kind == rk4sou_pkg::K_ST4) ? c.i2 : c.sv;
		ay = (pipe_s1.kind == rk4sou_pkg::K_ST4) ? c.i3 : rk4sou_pkg::half(c.i2);
		ad = rk4sou_pkg::sat_add(ax, ay);
		n2    = c;
		n2.pa = rk4sou_pkg::mul_full(c.acc, cfg_regs.step);
		n2.pb = rk4sou_pkg::mul_full(mx, mf);
		n2.wa = ad.val;
		if (pipe_s1.kind == rk4sou_pkg::K_ST3 || pipe_s1.kind == rk4sou_pkg::K_ST4) begin
			n2.clamp = ad.clamp;
		end
	end

	always_comb begin : st2
		rk4sou_pkg::sval_t ra, rb, ap;
		ra = rk4sou_pkg::rnd_sat(pipe_s2.pa);
		rb = rk4sou_pkg::rnd_sat(pipe_s2.pb);
		ap = rk4sou_pkg::sat_add(pipe_s2.i1, pipe_s2.wa);
		n3    = pipe_s2;
		n3.wb = ra.val;
		n3.wc = rb.val;
		n3.wd = ap.val;
		case (pipe_s2.kind)
			rk4sou_pkg::K_ST1: begin
				n3.i1    = ra.val;
				n3.clamp = pipe_s2.clamp | ra.clamp | rb.clamp;
			end
			rk4sou_pkg::K_ST2: begin
				n3.i2    = ra.val;
				n3.clamp = pipe_s2.clamp | ra.clamp | rb.clamp;
			end
			rk4sou_pkg::K_ST3: begin
				n3.i3    = ra.val;
				n3.clamp = pipe_s2.clamp | ra.clamp;
			end
			rk4sou_pkg::K_ST4: n3.clamp = pipe_s2.clamp | ra.clamp | ap.clamp;
			default: ;
		endcase
	end

	always_comb begin : st3
		rk4sou_pkg::sval_t                ap, av, aq;
		logic signed [rk4sou_pkg::DW-1:0] mx, mf, vx, vy;
		mx = (pipe_s3.kind == rk4sou_pkg::K_ST3) ? pipe_s3.wa : pipe_s3.wd;
		mf = (pipe_s3.kind == rk4sou_pkg::K_ST3) ? cfg_regs.step : rk4sou_pkg::SIXTH_Q;
		vx = (pipe_s3.kind == rk4sou_pkg::K_ST1) ? pipe_s3.vel : pipe_s3.sv;
		vy = (pipe_s3.kind == rk4sou_pkg::K_ST3) ? pipe_s3.wb : rk4sou_pkg::half(pipe_s3.wb);
		ap = rk4sou_pkg::sat_add(pipe_s3.pos, pipe_s3.wc);
		av = rk4sou_pkg::sat_add(vx, vy);
		aq = rk4sou_pkg::sat_add(pipe_s3.wd, pipe_s3.wa);
		n4    = pipe_s3;
		n4.pa = rk4sou_pkg::mul_full(mx, mf);
		case (pipe_s3.kind) inside
			rk4sou_pkg::K_ST1, rk4sou_pkg::K_ST2: begin
				n4.pos   = ap.val;
				n4.vel   = av.val;
				n4.clamp = pipe_s3.clamp | ap.clamp | av.clamp;
			end
			rk4sou_pkg::K_ST3: begin
				n4.vel   = av.val;
				n4.clamp = pipe_s3.clamp | av.clamp;
			end
			rk4sou_pkg::K_ST4: begin
				n4.wd    = aq.val;
				n4.clamp = pipe_s3.clamp | aq.clamp;
			end
			default: ;
		endcase
	end

	always_comb begin : st4
		rk4sou_pkg::sval_t ru, ar;
		ru = rk4sou_pkg::rnd_sat(pipe_s4.pa);
		ar = rk4sou_pkg::sat_add(pipe_s4.wd, pipe_s4.wb);
		n5    = pipe_s4;
		n5.wc = ru.val;
		n5.wd = ar.val;
		case (pipe_s4.kind)
			rk4sou_pkg::K_ST3: n5.clamp = pipe_s4.clamp | ru.clamp;
			rk4sou_pkg::K_ST4: n5.clamp = pipe_s4.clamp | ru.clamp | ar.clamp;
			default: ;
		endcase
	end

	always_comb begin : st5
		rk4sou_pkg::sval_t                a5;
		logic signed [rk4sou_pkg::DW-1:0] ax;
		ax = (pipe_s5.kind == rk4sou_pkg::K_ST3) ? pipe_s5.sp : pipe_s5.sv;
		a5 = rk4sou_pkg::sat_add(ax, pipe_s5.wc);
		n6    = pipe_s5;
		n6.pb = rk4sou_pkg::mul_full(pipe_s5.wd, rk4sou_pkg::SIXTH_Q);
		case (pipe_s5.kind)
			rk4sou_pkg::K_ST3: begin
				n6.pos   = a5.val;
				n6.clamp = pipe_s5.clamp | a5.clamp;
			end
			rk4sou_pkg::K_ST4: begin
				n6.wa    = a5.val;
				n6.clamp = pipe_s5.clamp | a5.clamp;
			end
			default: ;
		endcase
	end

	always_comb begin : st6
		rk4sou_pkg::sval_t rd;
		rd = rk4sou_pkg::rnd_sat(pipe_s6.pb);
		n7    = pipe_s6;
		n7.pa = rk4sou_pkg::mul_full(pipe_s6.wa, cfg_regs.step);
		n7.wc = rd.val;
		if (pipe_s6.kind == rk4sou_pkg::K_ST4) begin
			n7.clamp = pipe_s6.clamp | rd.clamp;
		end
	end

	always_comb begin : st7
		rk4sou_pkg::sval_t av, re;
		av = rk4sou_pkg::sat_add(pipe_s7.sv, pipe_s7.wc);
		re = rk4sou_pkg::rnd_sat(pipe_s7.pa);
		n8    = pipe_s7;
		n8.wb = re.val;
		if (pipe_s7.kind == rk4sou_pkg::K_ST4) begin
			n8.vel   = av.val;
			n8.clamp = pipe_s7.clamp | av.clamp | re.clamp;
		end
	end

	always_comb begin : st8
		rk4sou_pkg::sval_t ap;
		ap  = rk4sou_pkg::sat_add(pipe_s8.sp, pipe_s8.wb);
		fin = pipe_s8;
		if (pipe_s8.kind == rk4sou_pkg::K_ST4) begin
			fin.pos   = ap.val;
			fin.clamp = pipe_s8.clamp | ap.clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s1 <= n1;
		pipe_s2 <= n2;
		pipe_s3 <= n3;
		pipe_s4 <= n4;
		pipe_s5 <= n5;
		pipe_s6 <= n6;
		pipe_s7 <= n7;
		pipe_s8 <= n8;
	end

	always_comb begin
		wr_pv    = 1'b0;
		wr_start = 1'b0;
		wr_i2    = 1'b0;
		wr_i3    = 1'b0;
		case (pipe_s8.kind) inside
			rk4sou_pkg::K_LOAD, rk4sou_pkg::K_ST4: wr_pv = vld_s8;
			rk4sou_pkg::K_ST1: begin
				wr_pv    = vld_s8;
				wr_start = vld_s8;
			end
			rk4sou_pkg::K_ST2: begin
				wr_pv = vld_s8;
				wr_i2 = vld_s8;
			end
			rk4sou_pkg::K_ST3: begin
				wr_pv = vld_s8;
				wr_i3 = vld_s8;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_pv) begin
			pos_mem[pipe_s8.idx] <= fin.pos;
			vel_mem[pipe_s8.idx] <= fin.vel;
		end
		if (wr_start) begin
			spos_mem[pipe_s8.idx] <= fin.sp;
			svel_mem[pipe_s8.idx] <= fin.sv;
			inc1_mem[pipe_s8.idx] <= fin.i1;
		end
		if (wr_i2) begin
			inc2_mem[pipe_s8.idx] <= fin.i2;
		end
		if (wr_i3) begin
			inc3_mem[pipe_s8.idx] <= fin.i3;
		end
	end

	assign res_push      = vld_s8;
	assign res.out_index = pipe_s8.idx;
	assign res.out_pos   = fin.pos;
	assign res.out_vel   = fin.vel;
	assign res.saturated = fin.clamp;

endmodule

`default_nettype wire

// File: rtl/rk4sou_outq.sv
// Result queue of the RK4 stage update: holds finished result items until taken.
// Depends on rk4sou_pkg and rk4sou_rsp_if; space is reserved by the back end's credit count.
`default_nettype none

module rk4sou_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rk4sou_pkg::res_t      res,
	input  logic                  res_push,
	output logic                  res_pop,
	rk4sou_rsp_if.source          rsp
);

	rk4sou_pkg::res_t             oq_q [rk4sou_pkg::OQ_DEPTH];
	logic [rk4sou_pkg::OQ_AW-1:0] wr_ptr_q;
	logic [rk4sou_pkg::OQ_AW-1:0] rd_ptr_q;
	logic [rk4sou_pkg::OQ_CW-1:0] cnt_q;
	rk4sou_pkg::res_t             top_item;

	assign top_item      = oq_q[rd_ptr_q];
	assign rsp.valid     = (cnt_q != '0);
	assign rsp.out_index = top_item.out_index;
	assign rsp.out_pos   = top_item.out_pos;
	assign rsp.out_vel   = top_item.out_vel;
	assign rsp.saturated = top_item.saturated;
	assign res_pop       = rsp.valid && rsp.ready;

	always_ff @(posedge clk) begin
		if (res_push) begin
			oq_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + rk4sou_pkg::OQ_AW'(1);
			end
			if (res_pop) begin
				rd_ptr_q <= rd_ptr_q + rk4sou_pkg::OQ_AW'(1);
			end
			case ({res_push, res_pop})
				2'b10:   cnt_q <= cnt_q + rk4sou_pkg::OQ_CW'(1);
				2'b01:   cnt_q <= cnt_q - rk4sou_pkg::OQ_CW'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/rk4_second_order_stage_update.sv
// Top level of the RK4 second-order stage update: front end, stage pipeline, result queue.
// Depends on rk4sou_pkg, the three channel interfaces, rk4sou_front, rk4sou_back, rk4sou_outq.
//
// Usage:
//   req carries one item per handshake: opcode (load or stage 1..4), var_index, accel and
//   the load values. rsp returns exactly one result item per input item, in input order.
//   cfg writes step (index 0), pos_half_factor (1) and pos_corr_factor (2); cfg is always
//   ready; the user must make writes only while no item is in flight, unchecked by the block.
//   Throughput: one item per cycle while the result queue has room and no item names a
//   variable that one of the eight items ahead of it names. An item that names a variable
//   still in the eight-stage pipeline waits in the input queue until that variable's
//   write-back is done, so a variable takes no new item while its last one is in flight.
//   An accepted item passes the input queue, stage registers s1 to s8 and the result queue
//   before rsp shows its result; the variable check or a full result queue can hold it.
//   A stalled rsp fills the 16-entry result queue; issue stops when the queue has no room,
//   then the 4-entry input queue fills and req.ready drops. Nothing is lost.
//   Reset clears the queues, the pipeline and the configuration registers; the variable
//   memories are not cleared, so load a variable before running stages on it.
`default_nettype none

module rk4_second_order_stage_update (
	input  logic          clk,
	input  logic          arst_n,
	rk4sou_req_if.sink    req,
	rk4sou_cfg_if.sink    cfg,
	rk4sou_rsp_if.source  rsp
);

	rk4sou_pkg::cfg_t  cfg_regs;
	rk4sou_pkg::item_t head;
	logic              head_valid;
	logic              head_pop;
	rk4sou_pkg::res_t  res;
	logic              res_push;
	logic              res_pop;

	rk4sou_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.cfg_regs   (cfg_regs),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	rk4sou_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_regs),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.res        (res),
		.res_push   (res_push),
		.res_pop    (res_pop)
	);

	rk4sou_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.res_push (res_push),
		.res_pop  (res_pop),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// File: verif/rk4_second_order_stage_update_tb.sv
// Testbench for rk4_second_order_stage_update: a directed table, then random stage sequences
// under several register settings, checked by an in-bench fixed-point model or typed rows.
// Depends on rk4sou_pkg, the req/rsp/cfg channel interfaces and the RTL top level.
module rk4_second_order_stage_update_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rk4sou_pkg::*;

	localparam logic [OPW-1:0] OP_RSV5 = 3'd5;
	localparam logic [OPW-1:0] OP_RSV6 = 3'd6;
	localparam logic [OPW-1:0] OP_RSV7 = 3'd7;
	localparam longint ONE_HALF = 32768;
	localparam longint ONE_SIXTH = 10923;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 200;
	localparam int SLOTS = 16;
	localparam int DRAIN = 32;
	localparam int LIMIT = 400000;

	typedef struct packed {
		bit              cfg_row;
		logic [CFG_IW-1:0] cidx;
		logic [DW-1:0]   cdata;
		logic [OPW-1:0]  op;
		logic [IDXW-1:0] vi;
		logic [DW-1:0]   acc;
		logic [DW-1:0]   lp;
		logic [DW-1:0]   lv;
		bit              typed;
		res_t            want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	rk4sou_req_if req_ch ();
	rk4sou_cfg_if cfg_ch ();
	rk4sou_rsp_if rsp_ch ();

	rk4_second_order_stage_update uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	longint pos_m [NUM_VARS];
	longint vel_m [NUM_VARS];
	longint x0_m [NUM_VARS];
	longint v0_m [NUM_VARS];
	longint h1_m [NUM_VARS];
	longint h2_m [NUM_VARS];
	longint h3_m [NUM_VARS];
	bit     have_pv [NUM_VARS];
	bit     have_start [NUM_VARS];
	bit     have_h1 [NUM_VARS];
	bit     have_h2 [NUM_VARS];
	bit     have_h3 [NUM_VARS];
	longint k_step, k_half, k_corr;
	bit     clipped;

	res_t   expect_q [$];
	row_t   dir_tab [$];
	int     bad;
	int     accepted;
	int     burst_left;
	int     cycles;
	bit     cfg_on;

	function automatic longint clamp32(input longint x);
		if (x > Q_MAX) begin
			clipped = 1'b1;
			return Q_MAX;
		end
		if (x < Q_MIN) begin
			clipped = 1'b1;
			return Q_MIN;
		end
		return x;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		longint q;
		q = a * b + 32768;
		return clamp32(q >>> 16);
	endfunction

	function automatic longint fx_add(input longint a, input longint b);
		return clamp32(a + b);
	endfunction

	function automatic res_t advance(input logic [OPW-1:0] op, input logic [IDXW-1:0] vi,
		input logic [DW-1:0] acc, input logic [DW-1:0] lp, input logic [DW-1:0] lv);
		longint a, s, t;
		res_t   r;
		a = longint'($signed(acc));
		clipped = 1'b0;
		case (op)
			OP_LOAD: begin
				pos_m[vi] = longint'($signed(lp));
				vel_m[vi] = longint'($signed(lv));
				have_pv[vi] = 1'b1;
			end
			OP_ST1: begin
				x0_m[vi] = pos_m[vi];
				v0_m[vi] = vel_m[vi];
				h1_m[vi] = fx_mul(a, k_step);
				pos_m[vi] = fx_add(pos_m[vi], fx_mul(vel_m[vi], k_half));
				vel_m[vi] = fx_add(vel_m[vi], fx_mul(h1_m[vi], ONE_HALF));
				have_start[vi] = 1'b1;
				have_h1[vi] = 1'b1;
			end
			OP_ST2: begin
				h2_m[vi] = fx_mul(a, k_step);
				pos_m[vi] = fx_add(pos_m[vi], fx_mul(h1_m[vi], k_corr));
				vel_m[vi] = fx_add(v0_m[vi], fx_mul(h2_m[vi], ONE_HALF));
				have_h2[vi] = 1'b1;
			end
			OP_ST3: begin
				h3_m[vi] = fx_mul(a, k_step);
				t = fx_add(v0_m[vi], fx_mul(h2_m[vi], ONE_HALF));
				pos_m[vi] = fx_add(x0_m[vi], fx_mul(t, k_step));
				vel_m[vi] = fx_add(v0_m[vi], h3_m[vi]);
				have_h3[vi] = 1'b1;
			end
			OP_ST4: begin
				s = fx_add(h2_m[vi], h3_m[vi]);
				t = fx_add(v0_m[vi], fx_mul(fx_add(h1_m[vi], s), ONE_SIXTH));
				pos_m[vi] = fx_add(x0_m[vi], fx_mul(t, k_step));
				t = fx_add(fx_add(fx_add(h1_m[vi], s), s), fx_mul(a, k_step));
				vel_m[vi] = fx_add(v0_m[vi], fx_mul(t, ONE_SIXTH));
			end
			default: ;
		endcase
		r.out_index = vi;
		r.out_pos = pos_m[vi][DW-1:0];
		r.out_vel = vel_m[vi][DW-1:0];
		r.saturated = clipped;
		return r;
	endfunction

	// never touch a store entry before it has been written
	function automatic bit legal(input logic [OPW-1:0] op, input logic [IDXW-1:0] vi);
		case (op)
			OP_LOAD: return 1'b1;
			OP_ST1:  return have_pv[vi];
			OP_ST2:  return have_pv[vi] && have_h1[vi] && have_start[vi];
			OP_ST3:  return have_h2[vi] && have_start[vi];
			OP_ST4:  return have_start[vi] && have_h1[vi] && have_h2[vi] && have_h3[vi];
			default: return have_pv[vi];
		endcase
	endfunction

	function automatic logic [DW-1:0] q_val();
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 32'hFFFFFFFF;
					default: return 32'h00000000;
				endcase
			end
			default: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
		endcase
	endfunction

	function automatic row_t row_cfg(input logic [CFG_IW-1:0] ri, input logic [DW-1:0] d);
		row_t r;
		r = '0;
		r.cfg_row = 1'b1;
		r.cidx = ri;
		r.cdata = d;
		return r;
	endfunction

	function automatic row_t row_item(input logic [OPW-1:0] op, input logic [IDXW-1:0] vi,
		input logic [DW-1:0] acc, input logic [DW-1:0] lp, input logic [DW-1:0] lv);
		row_t r;
		r = '0;
		r.op = op;
		r.vi = vi;
		r.acc = acc;
		r.lp = lp;
		r.lv = lv;
		return r;
	endfunction

	function automatic row_t row_fix(input logic [OPW-1:0] op, input logic [IDXW-1:0] vi,
		input logic [DW-1:0] acc, input logic [DW-1:0] lp, input logic [DW-1:0] lv,
		input logic [DW-1:0] xp, input logic [DW-1:0] xv);
		row_t r;
		r = row_item(op, vi, acc, lp, lv);
		r.typed = 1'b1;
		r.want.out_index = vi;
		r.want.out_pos = xp;
		r.want.out_vel = xv;
		r.want.saturated = 1'b0;
		return r;
	endfunction

	task automatic push_item(input logic [OPW-1:0] op, input logic [IDXW-1:0] vi,
		input logic [DW-1:0] acc, input logic [DW-1:0] lp, input logic [DW-1:0] lv,
		input bit typed, input res_t want);
		res_t pred;
		if (cfg_on) begin
			cfg_ch.valid <= 1'b0;
			cfg_on = 1'b0;
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.var_index <= vi;
		req_ch.accel <= acc;
		req_ch.load_pos <= lp;
		req_ch.load_vel <= lv;
		do @(posedge clk); while (!req_ch.ready);
		pred = advance(op, vi, acc, lp, lv);
		expect_q.push_back(typed ? want : pred);
		accepted++;
		burst_left--;
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] ri, input logic [DW-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= ri;
		cfg_ch.data <= d;
		cfg_on = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		case (ri)
			CFG_STEP:     k_step = longint'($signed(d));
			CFG_POS_HALF: k_half = longint'($signed(d));
			CFG_POS_CORR: k_corr = longint'($signed(d));
			default: ;
		endcase
	endtask

	// hold the sender and let every outstanding result come back
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (expect_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin : check_results
		res_t got, want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.out_index = rsp_ch.out_index;
			got.out_pos = rsp_ch.out_pos;
			got.out_vel = rsp_ch.out_vel;
			got.saturated = rsp_ch.saturated;
			if (expect_q.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("unexpected result item: var %0d pos %h vel %h sat %b",
						got.out_index, got.out_pos, got.out_vel, got.saturated);
			end else begin
				want = expect_q.pop_front();
				if (got.out_index !== want.out_index || got.out_pos !== want.out_pos ||
					got.out_vel !== want.out_vel || got.saturated !== want.saturated) begin
					bad++;
					if (bad <= 10)
						$display("mismatch: want %0d %h %h %b, got %0d %h %h %b",
							want.out_index, want.out_pos, want.out_vel, want.saturated,
							got.out_index, got.out_pos, got.out_vel, got.saturated);
				end
			end
		end
	end

	initial begin : drain_side
		int seg_len, stall_pct, hold;
		bit held;
		held = 1'b0;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			seg_len = $urandom_range(16, 160);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
			repeat (seg_len) begin
				@(posedge clk);
				if (!held && accepted >= 500) begin
					held = 1'b1;
					hold = 400;
				end
				if (hold > 0) begin
					hold--;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
				end
			end
		end
	end

	initial begin : stimulus
		int ph, n, k;
		logic [OPW-1:0]  op;
		logic [IDXW-1:0] vi;
		logic [DW-1:0]   acc, lp, lv, st, hf, cr;
		logic [IDXW-1:0] slot_vi [SLOTS];
		int              slot_nx [SLOTS];

		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_LOAD;
		req_ch.var_index <= '0;
		req_ch.accel <= '0;
		req_ch.load_pos <= '0;
		req_ch.load_vel <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_STEP;
		cfg_ch.data <= '0;
		bad = 0;
		accepted = 0;
		cycles = 0;
		cfg_on = 1'b0;
		k_step = 0;
		k_half = 0;
		k_corr = 0;
		burst_left = $urandom_range(1, 40);
		for (k = 0; k < SLOTS; k++) begin
			slot_vi[k] = IDXW'($urandom_range(0, NUM_VARS - 1));
			slot_nx[k] = 0;
		end

		dir_tab = '{
			row_fix(OP_LOAD, 10'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
				32'h7FFFFFFF, 32'h80000000),
			row_fix(OP_LOAD, 10'd1023, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
				32'h80000000, 32'h7FFFFFFF),
			row_fix(OP_RSV5, 10'd0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF,
				32'h7FFFFFFF, 32'h80000000),
			row_fix(OP_RSV6, 10'd1023, 32'hFFFFFFFF, 32'h0, 32'h0,
				32'h80000000, 32'h7FFFFFFF),
			row_fix(OP_RSV7, 10'd0, 32'h80000000, 32'h0, 32'h0,
				32'h7FFFFFFF, 32'h80000000),
			row_fix(OP_ST1, 10'd0, 32'h7FFFFFFF, 32'h0, 32'h0,
				32'h7FFFFFFF, 32'h80000000),
			row_fix(OP_ST1, 10'd1023, 32'h80000000, 32'h0, 32'h0,
				32'h80000000, 32'h7FFFFFFF),
			row_cfg(CFG_STEP, 32'h7FFFFFFF),
			row_cfg(CFG_POS_HALF, 32'h80000000),
			row_cfg(CFG_POS_CORR, 32'h7FFFFFFF),
			row_item(OP_ST2, 10'd1023, 32'h7FFFFFFF, 32'h0, 32'h0),
			row_item(OP_ST3, 10'd1023, 32'h80000000, 32'h0, 32'h0),
			row_item(OP_ST4, 10'd1023, 32'h7FFFFFFF, 32'h0, 32'h0),
			row_item(OP_ST1, 10'd0, 32'h80000000, 32'h0, 32'h0),
			row_item(OP_ST2, 10'd0, 32'h00000001, 32'h0, 32'h0),
			row_item(OP_ST3, 10'd0, 32'hFFFFFFFF, 32'h0, 32'h0),
			row_item(OP_ST4, 10'd0, 32'h00000000, 32'h0, 32'h0),
			row_cfg(CFG_STEP, 32'h00010000),
			row_cfg(CFG_POS_HALF, 32'h00008000),
			row_cfg(CFG_POS_CORR, 32'hFFFF8000),
			row_fix(OP_LOAD, 10'd512, 32'h0, 32'h00010000, 32'hFFFF0000,
				32'h00010000, 32'hFFFF0000),
			row_item(OP_ST1, 10'd512, 32'h00020000, 32'h0, 32'h0),
			row_item(OP_ST2, 10'd512, 32'hFFFE0000, 32'h0, 32'h0),
			row_item(OP_ST3, 10'd512, 32'h00018000, 32'h0, 32'h0),
			row_item(OP_ST4, 10'd512, 32'h00008000, 32'h0, 32'h0),
			row_fix(OP_LOAD, 10'd341, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
			row_item(OP_ST1, 10'd341, 32'h80000000, 32'h0, 32'h0),
			row_fix(OP_LOAD, 10'd682, 32'h0, 32'h7FFFFFFF, 32'h00000001,
				32'h7FFFFFFF, 32'h00000001)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg_row) begin
				if (!cfg_on)
					settle();
				write_reg(dir_tab[i].cidx, dir_tab[i].cdata);
			end else begin
				push_item(dir_tab[i].op, dir_tab[i].vi, dir_tab[i].acc, dir_tab[i].lp,
					dir_tab[i].lv, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					st = 32'h00001000;
					hf = 32'h00000800;
					cr = 32'h00000155;
				end
				1: begin
					st = 32'h7FFFFFFF;
					hf = 32'h7FFFFFFF;
					cr = 32'h80000000;
				end
				2: begin
					st = 32'h80000000;
					hf = 32'h80000000;
					cr = 32'h7FFFFFFF;
				end
				3: begin
					st = 32'h0;
					hf = 32'h0;
					cr = 32'h0;
				end
				4: begin
					st = $urandom;
					hf = $urandom;
					cr = $urandom;
				end
				default: begin
					st = $urandom_range(0, 32'h3FFFF) - 32'h20000;
					hf = $urandom_range(0, 32'h3FFFF) - 32'h20000;
					cr = $urandom_range(0, 32'h3FFFF) - 32'h20000;
				end
			endcase
			settle();
			write_reg(CFG_STEP, st);
			write_reg(CFG_POS_HALF, hf);
			write_reg(CFG_POS_CORR, cr);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				k = $urandom_range(0, SLOTS - 1);
				acc = q_val();
				lp = q_val();
				lv = q_val();
				if ($urandom_range(0, 99) < 85) begin
					op = OPW'(slot_nx[k]);
					vi = slot_vi[k];
					if (!legal(op, vi))
						op = OP_LOAD;
					if (op == OP_ST4) begin
						slot_nx[k] = ($urandom_range(0, 3) == 0) ? 0 : 1;
						if (slot_nx[k] == 0)
							slot_vi[k] = IDXW'($urandom_range(0, NUM_VARS - 1));
					end else begin
						slot_nx[k] = int'(op) + 1;
					end
				end else begin
					op = OPW'($urandom_range(0, 7));
					vi = $urandom_range(0, 1) ? slot_vi[k]
						: IDXW'($urandom_range(0, NUM_VARS - 1));
					if (!legal(op, vi))
						op = OP_LOAD;
				end
				push_item(op, vi, acc, lp, lv, 1'b0, '0);
			end
		end

		settle();
		repeat (DRAIN) @(posedge clk);
		if (bad == 0 && expect_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
